// ===== design/bsmb_pkg.sv =====
// shared types, constants and helpers for the bayer sparse mean brightness block
`timescale 1ns / 1ps
`default_nettype none
package bsmb_pkg;

	localparam int COORD_BITS  = 12;
	localparam int BLOCK_BITS  = 9;
	localparam int PIXEL_BITS  = 8;
	localparam int WEIGHT_BITS = 16;
	localparam int PROD_BITS   = PIXEL_BITS + WEIGHT_BITS;
	localparam int ACC_BITS    = 48;
	localparam int OUT_BITS    = 26;
	localparam int MAX_BLOCKS  = 256;
	localparam int Q_BITS      = 17;
	localparam int DIV_BITS    = ACC_BITS + 1;
	localparam int CNT_BITS    = 6;
	localparam int ADDR_BITS   = 5;
	localparam int DATA_BITS   = 32;

	localparam logic [BLOCK_BITS-1:0] BLOCK_SAT = {BLOCK_BITS{1'b1}};
	localparam logic [BLOCK_BITS-1:0] BLOCK_MAX = BLOCK_BITS'(MAX_BLOCKS);

	typedef enum logic [2:0] {
		REG_STRIDE_X     = 3'd0,
		REG_STRIDE_Y     = 3'd1,
		REG_BLOCKS_X     = 3'd2,
		REG_BLOCKS_Y     = 3'd3,
		REG_WEIGHT_RED   = 3'd4,
		REG_WEIGHT_GREEN = 3'd5,
		REG_WEIGHT_BLUE  = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		W_BLUE,
		W_GREEN,
		W_RED
	} wsel_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]  stride_x;
		logic [COORD_BITS-1:0]  stride_y;
		logic [BLOCK_BITS-1:0]  blocks_x;
		logic [BLOCK_BITS-1:0]  blocks_y;
		logic [WEIGHT_BITS-1:0] weight_red;
		logic [WEIGHT_BITS-1:0] weight_green;
		logic [WEIGHT_BITS-1:0] weight_blue;
	} cfg_t;

	typedef struct packed {
		logic  hit;
		wsel_t wsel;
		logic  pos_zero;
	} grid_out_t;

	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic div_load;
		logic div_step;
		logic out_load;
	} alu_ctrl_t;

	typedef struct packed {
		logic div_last;
		logic acc_zero;
	} alu_status_t;

	function automatic logic [BLOCK_BITS-1:0] eff_blocks(input logic [BLOCK_BITS-1:0] b);
		eff_blocks = (b > BLOCK_MAX) ? BLOCK_MAX : b;
	endfunction

endpackage
`default_nettype wire

// ===== design/bayer_sparse_mean_brightness.sv =====
// top level: weighted bggr quad mean over a sparse sample grid, one result per frame
// a pixel beat steps through the shared mac in order: accept, multiply, accumulate
// a frame-end beat then adds a divider load, the bit-serial divide and a step to register the mean:
// the next beat is taken only once the mean is registered, later while a previous mean is
// still stalled in the output register
// the output register holds the mean while pixels of the next frame are taken
// arst_n clears counters, accumulator, sequencer and registers to their defaults
`timescale 1ns / 1ps
`default_nettype none
module bayer_sparse_mean_brightness (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [bsmb_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [bsmb_pkg::DATA_BITS-1:0] pwdata,
	output logic      [bsmb_pkg::DATA_BITS-1:0] prdata,
	output logic                                pready,
	input  wire logic [bsmb_pkg::PIXEL_BITS-1:0] pixel,
	input  wire logic                           line_end,
	input  wire logic                           frame_end,
	input  wire logic                           pix_valid,
	output logic                                pix_stall,
	output logic      [bsmb_pkg::OUT_BITS-1:0]  mean_brightness,
	output logic                                mean_valid,
	input  wire logic                           mean_stall
);

	bsmb_pkg::cfg_t              cfg;
	logic [bsmb_pkg::Q_BITS-1:0] quads;
	bsmb_pkg::grid_out_t         grid;
	bsmb_pkg::alu_ctrl_t         ctrl;
	bsmb_pkg::alu_status_t       status;
	logic                        accept;

	bsmb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.quads   (quads)
	);

	bsmb_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.frame_end  (frame_end),
		.mean_stall (mean_stall),
		.status     (status),
		.pix_stall  (pix_stall),
		.accept     (accept),
		.mean_valid (mean_valid),
		.ctrl       (ctrl)
	);

	bsmb_grid u_grid (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.line_end  (line_end),
		.frame_end (frame_end),
		.cfg       (cfg),
		.grid      (grid)
	);

	bsmb_alu u_alu (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.pixel           (pixel),
		.grid            (grid),
		.cfg             (cfg),
		.quads           (quads),
		.ctrl            (ctrl),
		.status          (status),
		.mean_brightness (mean_brightness)
	);

	// one beat at a time through the shared datapath
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pix_stall)
		else $error("pixel taken while datapath busy");

	a_frame_end_clears_grid: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_end |=> grid.pos_zero)
		else $error("grid position not cleared after frame end");

	a_acc_cleared_at_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mean_valid) |-> status.acc_zero)
		else $error("accumulator not cleared when mean is presented");

	a_load_only_after_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> $past(ctrl.div_step) || $past(ctrl.out_load) || mean_valid)
		else $error("mean loaded before divider finished");

endmodule
`default_nettype wire

// ===== design/bsmb_cfg.sv =====
// apb register file with the registered quad count
`timescale 1ns / 1ps
`default_nettype none
module bsmb_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [bsmb_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [bsmb_pkg::DATA_BITS-1:0] pwdata,
	output logic      [bsmb_pkg::DATA_BITS-1:0] prdata,
	output logic                                pready,
	output bsmb_pkg::cfg_t                      cfg,
	output logic      [bsmb_pkg::Q_BITS-1:0]    quads
);

	bsmb_pkg::cfg_t                    cfg_q;
	logic [bsmb_pkg::Q_BITS-1:0]       quads_q;
	bsmb_pkg::reg_idx_t                idx;
	logic                              wr;
	logic [2*bsmb_pkg::BLOCK_BITS-1:0] prod;

	assign idx    = bsmb_pkg::reg_idx_t'(paddr[bsmb_pkg::ADDR_BITS-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stride_x     <= bsmb_pkg::COORD_BITS'(80);
			cfg_q.stride_y     <= bsmb_pkg::COORD_BITS'(64);
			cfg_q.blocks_x     <= bsmb_pkg::BLOCK_BITS'(16);
			cfg_q.blocks_y     <= bsmb_pkg::BLOCK_BITS'(16);
			cfg_q.weight_red   <= bsmb_pkg::WEIGHT_BITS'(4899);
			cfg_q.weight_green <= bsmb_pkg::WEIGHT_BITS'(4809);
			cfg_q.weight_blue  <= bsmb_pkg::WEIGHT_BITS'(1868);
		end else if (wr) begin
			case (idx)
				bsmb_pkg::REG_STRIDE_X:     cfg_q.stride_x     <= pwdata[bsmb_pkg::COORD_BITS-1:0];
				bsmb_pkg::REG_STRIDE_Y:     cfg_q.stride_y     <= pwdata[bsmb_pkg::COORD_BITS-1:0];
				bsmb_pkg::REG_BLOCKS_X:     cfg_q.blocks_x     <= pwdata[bsmb_pkg::BLOCK_BITS-1:0];
				bsmb_pkg::REG_BLOCKS_Y:     cfg_q.blocks_y     <= pwdata[bsmb_pkg::BLOCK_BITS-1:0];
				bsmb_pkg::REG_WEIGHT_RED:   cfg_q.weight_red   <= pwdata[bsmb_pkg::WEIGHT_BITS-1:0];
				bsmb_pkg::REG_WEIGHT_GREEN: cfg_q.weight_green <= pwdata[bsmb_pkg::WEIGHT_BITS-1:0];
				bsmb_pkg::REG_WEIGHT_BLUE:  cfg_q.weight_blue  <= pwdata[bsmb_pkg::WEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// quad count is registered from the block registers, in the cycle after they change
	assign prod = {{bsmb_pkg::BLOCK_BITS{1'b0}}, bsmb_pkg::eff_blocks(cfg_q.blocks_x)}
		* {{bsmb_pkg::BLOCK_BITS{1'b0}}, bsmb_pkg::eff_blocks(cfg_q.blocks_y)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quads_q <= bsmb_pkg::Q_BITS'(256);
		end else begin
			quads_q <= prod[bsmb_pkg::Q_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			bsmb_pkg::REG_STRIDE_X:     prdata = bsmb_pkg::DATA_BITS'(cfg_q.stride_x);
			bsmb_pkg::REG_STRIDE_Y:     prdata = bsmb_pkg::DATA_BITS'(cfg_q.stride_y);
			bsmb_pkg::REG_BLOCKS_X:     prdata = bsmb_pkg::DATA_BITS'(cfg_q.blocks_x);
			bsmb_pkg::REG_BLOCKS_Y:     prdata = bsmb_pkg::DATA_BITS'(cfg_q.blocks_y);
			bsmb_pkg::REG_WEIGHT_RED:   prdata = bsmb_pkg::DATA_BITS'(cfg_q.weight_red);
			bsmb_pkg::REG_WEIGHT_GREEN: prdata = bsmb_pkg::DATA_BITS'(cfg_q.weight_green);
			bsmb_pkg::REG_WEIGHT_BLUE:  prdata = bsmb_pkg::DATA_BITS'(cfg_q.weight_blue);
			default:                    prdata = '0;
		endcase
	end

	assign cfg   = cfg_q;
	assign quads = quads_q;

endmodule
`default_nettype wire

// ===== design/bsmb_grid.sv =====
// raster position counters and sample grid decision
`timescale 1ns / 1ps
`default_nettype none
module bsmb_grid (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              line_end,
	input  wire logic              frame_end,
	input  bsmb_pkg::cfg_t         cfg,
	output bsmb_pkg::grid_out_t    grid
);

	logic [bsmb_pkg::COORD_BITS-1:0] col_phase_q, row_phase_q;
	logic [bsmb_pkg::BLOCK_BITS-1:0] col_block_q, row_block_q;
	logic [bsmb_pkg::COORD_BITS-1:0] col_phase_nx, row_phase_nx;
	logic [bsmb_pkg::BLOCK_BITS-1:0] col_block_nx, row_block_nx;
	logic [bsmb_pkg::BLOCK_BITS-1:0] bx, by;

	function automatic logic [bsmb_pkg::COORD_BITS+bsmb_pkg::BLOCK_BITS-1:0] step_pos(
		input logic [bsmb_pkg::COORD_BITS-1:0] phase,
		input logic [bsmb_pkg::BLOCK_BITS-1:0] block,
		input logic [bsmb_pkg::COORD_BITS-1:0] stride
	);
		logic [bsmb_pkg::COORD_BITS:0]   inc;
		logic [bsmb_pkg::BLOCK_BITS-1:0] blk;
		inc = {1'b0, phase} + 1'b1;
		blk = block;
		if (inc >= {1'b0, stride}) begin
			if (block != bsmb_pkg::BLOCK_SAT) begin
				blk = block + 1'b1;
			end
			step_pos = {{bsmb_pkg::COORD_BITS{1'b0}}, blk};
		end else begin
			step_pos = {inc[bsmb_pkg::COORD_BITS-1:0], block};
		end
	endfunction

	assign bx = bsmb_pkg::eff_blocks(cfg.blocks_x);
	assign by = bsmb_pkg::eff_blocks(cfg.blocks_y);

	always_comb begin
		col_phase_nx = col_phase_q;
		col_block_nx = col_block_q;
		row_phase_nx = row_phase_q;
		row_block_nx = row_block_q;
		if (frame_end) begin
			col_phase_nx = '0;
			col_block_nx = '0;
			row_phase_nx = '0;
			row_block_nx = '0;
		end else if (line_end) begin
			col_phase_nx = '0;
			col_block_nx = '0;
			{row_phase_nx, row_block_nx} = step_pos(row_phase_q, row_block_q, cfg.stride_y);
		end else begin
			{col_phase_nx, col_block_nx} = step_pos(col_phase_q, col_block_q, cfg.stride_x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_phase_q <= '0;
			col_block_q <= '0;
			row_phase_q <= '0;
			row_block_q <= '0;
		end else if (accept) begin
			col_phase_q <= col_phase_nx;
			col_block_q <= col_block_nx;
			row_phase_q <= row_phase_nx;
			row_block_q <= row_block_nx;
		end
	end

	always_comb begin
		grid.hit = (col_phase_q < bsmb_pkg::COORD_BITS'(2)) && (row_phase_q < bsmb_pkg::COORD_BITS'(2))
			&& (col_block_q < bx) && (row_block_q < by);
		// bggr quad: blue top-left, red bottom-right
		if (row_phase_q == '0) begin
			grid.wsel = (col_phase_q == '0) ? bsmb_pkg::W_BLUE : bsmb_pkg::W_GREEN;
		end else begin
			grid.wsel = (col_phase_q == '0) ? bsmb_pkg::W_GREEN : bsmb_pkg::W_RED;
		end
		grid.pos_zero = (col_phase_q == '0) && (col_block_q == '0)
			&& (row_phase_q == '0) && (row_block_q == '0);
	end

endmodule
`default_nettype wire

// ===== design/bsmb_alu.sv =====
// multiply-accumulate datapath and bit-serial divider with output register
`timescale 1ns / 1ps
`default_nettype none
module bsmb_alu (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             accept,
	input  wire logic [bsmb_pkg::PIXEL_BITS-1:0]  pixel,
	input  bsmb_pkg::grid_out_t                   grid,
	input  bsmb_pkg::cfg_t                        cfg,
	input  wire logic [bsmb_pkg::Q_BITS-1:0]      quads,
	input  bsmb_pkg::alu_ctrl_t                   ctrl,
	output bsmb_pkg::alu_status_t                 status,
	output logic      [bsmb_pkg::OUT_BITS-1:0]    mean_brightness
);

	logic [bsmb_pkg::PIXEL_BITS-1:0]  pix_q;
	logic [bsmb_pkg::WEIGHT_BITS-1:0] w_q;
	logic [bsmb_pkg::PROD_BITS-1:0]   prod_q;
	logic [bsmb_pkg::ACC_BITS-1:0]    acc_q;
	logic [bsmb_pkg::DIV_BITS-1:0]    dq_q;
	logic [bsmb_pkg::Q_BITS-1:0]      rem_q;
	logic [bsmb_pkg::CNT_BITS-1:0]    cnt_q;
	logic [bsmb_pkg::OUT_BITS-1:0]    mean_q;
	logic [bsmb_pkg::WEIGHT_BITS-1:0] w_sel;
	logic [bsmb_pkg::Q_BITS:0]        trial, diff;
	logic                             ge;
	logic                             sat;
	logic [bsmb_pkg::OUT_BITS-1:0]    mean_nx;

	always_comb begin
		case (grid.wsel)
			bsmb_pkg::W_BLUE:  w_sel = cfg.weight_blue;
			bsmb_pkg::W_GREEN: w_sel = cfg.weight_green;
			bsmb_pkg::W_RED:   w_sel = cfg.weight_red;
			default:           w_sel = '0;
		endcase
	end

	// restoring division step: shift one dividend bit into the remainder
	assign trial = {rem_q, dq_q[bsmb_pkg::DIV_BITS-1]};
	assign ge    = trial >= {1'b0, quads};
	assign diff  = trial - {1'b0, quads};

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pixel;
			w_q   <= grid.hit ? w_sel : '0;
		end
		if (ctrl.mul_en) begin
			prod_q <= {{bsmb_pkg::WEIGHT_BITS{1'b0}}, pix_q}
				* {{bsmb_pkg::PIXEL_BITS{1'b0}}, w_q};
		end
		if (ctrl.div_load) begin
			// round half up before the divide
			dq_q  <= {1'b0, acc_q} + bsmb_pkg::DIV_BITS'(quads >> 1);
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			dq_q  <= {dq_q[bsmb_pkg::DIV_BITS-2:0], ge};
			rem_q <= ge ? diff[bsmb_pkg::Q_BITS-1:0] : trial[bsmb_pkg::Q_BITS-1:0];
		end
		if (ctrl.out_load) begin
			mean_q <= mean_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			if (ctrl.div_load) begin
				acc_q <= '0;
			end else if (ctrl.acc_en) begin
				acc_q <= acc_q + bsmb_pkg::ACC_BITS'(prod_q);
			end
			if (ctrl.div_load) begin
				cnt_q <= '0;
			end else if (ctrl.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign sat = |dq_q[bsmb_pkg::DIV_BITS-1:bsmb_pkg::OUT_BITS];

	always_comb begin
		if (quads == '0) begin
			mean_nx = '0;
		end else if (sat) begin
			mean_nx = '1;
		end else begin
			mean_nx = dq_q[bsmb_pkg::OUT_BITS-1:0];
		end
	end

	assign status.div_last  = cnt_q == bsmb_pkg::CNT_BITS'(bsmb_pkg::DIV_BITS - 1);
	assign status.acc_zero  = acc_q == '0;
	assign mean_brightness  = mean_q;

endmodule
`default_nettype wire

// ===== design/bsmb_seq.sv =====
// sequencer that steps the shared datapath through one pixel or one frame-end divide
`timescale 1ns / 1ps
`default_nettype none
module bsmb_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pix_valid,
	input  wire logic            frame_end,
	input  wire logic            mean_stall,
	input  bsmb_pkg::alu_status_t status,
	output logic                 pix_stall,
	output logic                 accept,
	output logic                 mean_valid,
	output bsmb_pkg::alu_ctrl_t  ctrl
);

	bsmb_pkg::seq_state_t state_q, state_nx;
	logic                 fend_q;
	logic                 mean_valid_q;
	logic                 out_free;

	assign pix_stall = state_q != bsmb_pkg::ST_IDLE;
	assign accept    = pix_valid && !pix_stall;
	assign out_free  = !mean_valid_q || !mean_stall;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			bsmb_pkg::ST_IDLE: if (accept) state_nx = bsmb_pkg::ST_MUL;
			bsmb_pkg::ST_MUL:  state_nx = bsmb_pkg::ST_ADD;
			bsmb_pkg::ST_ADD:  state_nx = fend_q ? bsmb_pkg::ST_LOAD : bsmb_pkg::ST_IDLE;
			bsmb_pkg::ST_LOAD: state_nx = bsmb_pkg::ST_DIV;
			bsmb_pkg::ST_DIV:  if (status.div_last) state_nx = bsmb_pkg::ST_DONE;
			bsmb_pkg::ST_DONE: if (out_free) state_nx = bsmb_pkg::ST_IDLE;
			default:           state_nx = bsmb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			bsmb_pkg::ST_MUL:  ctrl.mul_en   = 1'b1;
			bsmb_pkg::ST_ADD:  ctrl.acc_en   = 1'b1;
			bsmb_pkg::ST_LOAD: ctrl.div_load = 1'b1;
			bsmb_pkg::ST_DIV:  ctrl.div_step = 1'b1;
			bsmb_pkg::ST_DONE: ctrl.out_load = out_free;
			default:           ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bsmb_pkg::ST_IDLE;
			fend_q       <= 1'b0;
			mean_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				fend_q <= frame_end;
			end
			if (ctrl.out_load) begin
				mean_valid_q <= 1'b1;
			end else if (!mean_stall) begin
				mean_valid_q <= 1'b0;
			end
		end
	end

	assign mean_valid = mean_valid_q;

endmodule
`default_nettype wire
